FILE: sv/sftkd_pkg.sv
// shared types and constants for the serial frame touch/key decoder
// no dependencies; imported by every module of the block
`default_nettype none

package sftkd_pkg;

  // framing bytes and packet ids
  localparam logic [7:0] SOF_BYTE     = 8'h02;
  localparam logic [7:0] EOF_BYTE     = 8'h03;
  localparam logic [3:0] ID_LIMIT     = 4'd14;
  localparam logic [3:0] ID_KEY       = 4'd2;
  localparam logic [3:0] ID_TOUCH     = 4'd3;
  localparam logic [6:0] KEY_CODE_MIN = 7'd1;
  localparam logic [6:0] KEY_CODE_MAX = 7'd9;

  // number of payload bytes kept per frame
  localparam int HEAD_BYTES = 4;

  // frame queue between parser and decoder; depth is a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one accepted frame, as handed from parser to decoder
  typedef struct packed {
    logic [3:0]                 id;
    logic                       len_zero;
    logic [HEAD_BYTES-1:0][7:0] head;
  } frame_t;

  // one decoded result
  typedef struct packed {
    logic [3:0]  packet_id;
    logic        key_valid;
    logic [3:0]  key_code;
    logic        key_pressed;
    logic        touch_press;
    logic        coord_valid;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic        touch_release;
  } result_t;

  // queue handshake toward the decoder
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } q_out_t;

endpackage

`default_nettype wire

FILE: sv/sftkd_front.sv
// frame parser: hunts for start byte, checks id and closing byte (end marker or sum), pushes accepted frames
// depends on sftkd_pkg
`default_nettype none

module sftkd_front import sftkd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic [7:0] in_rx_byte,
  output logic            push,
  output frame_t          push_frame
);

  typedef enum logic [1:0] {PH_HUNT, PH_HEAD, PH_BODY, PH_CLOSE} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  id_r, id_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [HEAD_BYTES-1:0][7:0] head_r, head_nxt;
  logic [3:0]  idx_inc;

  assign idx_inc = idx_r + 4'd1;

  // next-state logic for one byte transfer
  always_comb begin
    phase_nxt = phase_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    head_nxt  = head_r;
    push      = 1'b0;
    if (in_fire) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (in_rx_byte == SOF_BYTE) phase_nxt = PH_HEAD;
        end
        PH_HEAD: begin
          id_nxt  = in_rx_byte[7:4];
          len_nxt = in_rx_byte[3:0];
          idx_nxt = 4'd0;
          if (in_rx_byte[7:4] >= ID_LIMIT) begin
            phase_nxt = PH_HUNT;
          end else begin
            sum_nxt   = in_rx_byte;
            phase_nxt = (in_rx_byte[3:0] != 4'd0) ? PH_BODY : PH_CLOSE;
          end
        end
        PH_BODY: begin
          sum_nxt = sum_r + in_rx_byte;
          if (idx_r < 4'(HEAD_BYTES)) head_nxt[idx_r[1:0]] = in_rx_byte;
          idx_nxt = idx_inc;
          if (idx_inc == len_r) phase_nxt = PH_CLOSE;
        end
        PH_CLOSE: begin
          phase_nxt = PH_HUNT;
          // closing byte accepts on the fixed end marker or the running sum
          if (in_rx_byte == EOF_BYTE || in_rx_byte == sum_r) push = 1'b1;
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  // frame record pushed on the closing byte
  assign push_frame.id       = id_r;
  assign push_frame.len_zero = (len_r == 4'd0);
  assign push_frame.head     = head_r;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      id_r    <= 4'd0;
      len_r   <= 4'd0;
      idx_r   <= 4'd0;
      sum_r   <= 8'd0;
      head_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
      head_r  <= head_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sftkd_queue.sv
// small register queue of accepted frames between parser and decoder
// depends on sftkd_pkg
`default_nettype none

module sftkd_queue import sftkd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire frame_t push_frame,
  output logic        not_full,
  input  wire logic   pop,
  output q_out_t      q_out
);

  frame_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign not_full    = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign q_out.valid = (cnt_r != '0);
  assign q_out.frame = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // frame storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_frame;
  end

endmodule

`default_nettype wire

FILE: sv/sftkd_back.sv
// frame decoder: turns queued frames into key/touch results, tracks contact
// depends on sftkd_pkg
`default_nettype none

module sftkd_back import sftkd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire q_out_t q_out,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output result_t     result
);

  logic    valid_r, valid_nxt;
  logic    contact_r, contact_nxt;
  result_t res_r, res_nxt;
  logic [6:0] code;
  logic       code_ok;
  frame_t     f;

  assign f         = q_out.frame;
  assign pop       = q_out.valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign result    = res_r;

  assign code    = f.head[0][6:0];
  assign code_ok = (code >= KEY_CODE_MIN) && (code <= KEY_CODE_MAX);

  // decode of the frame at the head of the queue
  always_comb begin
    res_nxt           = '0;
    res_nxt.packet_id = f.id;
    contact_nxt       = contact_r;
    if (f.id == ID_KEY) begin
      res_nxt.key_valid   = code_ok;
      res_nxt.key_code    = code_ok ? code[3:0] : 4'd0;
      res_nxt.key_pressed = code_ok & ~f.head[0][7];
    end else if (f.id == ID_TOUCH) begin
      res_nxt.touch_press = ~contact_r;
      if (!f.len_zero) begin
        res_nxt.coord_valid = 1'b1;
        res_nxt.x_pos       = {f.head[0], f.head[1]};
        res_nxt.y_pos       = {f.head[2], f.head[3]};
        contact_nxt         = 1'b1;
      end else begin
        res_nxt.touch_release = 1'b1;
        contact_nxt           = 1'b0;
      end
    end
    valid_nxt = pop ? 1'b1 : (valid_r && !out_ready);
  end

  // output register and contact flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      contact_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (pop) contact_r <= contact_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) res_r <= res_nxt;
  end

endmodule

`default_nettype wire

FILE: sv/serial_frame_touch_key_decoder_unit.sv
// Serial frame decoder for key and touch events. One received byte is taken per
// cycle on in_rx_byte while in_ready is high; a frame is start byte 0x02, an
// id/length byte, the payload and a closing byte that must be 0x03 or the 8-bit
// sum of the id byte and payload. Each accepted frame yields one result, which is
// registered in the frame queue and then in the result register. The parser never
// stalls by itself: in_ready drops only when the two-entry frame queue in front of
// the decoder is full, which takes a held-off out_ready. Results leave at up to one
// per cycle while out_ready is high. Touch contact state is kept across frames;
// the first four payload bytes persist between frames and reset to zero.
// depends on sftkd_pkg, sftkd_front, sftkd_queue, sftkd_back
`default_nettype none

module serial_frame_touch_key_decoder_unit import sftkd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_packet_id,
  output logic             out_key_valid,
  output logic [3:0]       out_key_code,
  output logic             out_key_pressed,
  output logic             out_touch_press,
  output logic             out_coord_valid,
  output logic [15:0]      out_x_pos,
  output logic [15:0]      out_y_pos,
  output logic             out_touch_release
);

  logic    in_fire;
  logic    push;
  frame_t  push_frame;
  logic    q_not_full;
  logic    pop;
  q_out_t  q_out;
  result_t result;

  assign in_ready = q_not_full;
  assign in_fire  = in_valid && in_ready;

  // byte parser
  sftkd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_rx_byte (in_rx_byte),
    .push       (push),
    .push_frame (push_frame)
  );

  // frame queue
  sftkd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .not_full   (q_not_full),
    .pop        (pop),
    .q_out      (q_out)
  );

  // frame decoder
  sftkd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_out     (q_out),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign out_packet_id     = result.packet_id;
  assign out_key_valid     = result.key_valid;
  assign out_key_code      = result.key_code;
  assign out_key_pressed   = result.key_pressed;
  assign out_touch_press   = result.touch_press;
  assign out_coord_valid   = result.coord_valid;
  assign out_x_pos         = result.x_pos;
  assign out_y_pos         = result.y_pos;
  assign out_touch_release = result.touch_release;

  // a frame is only pushed while the queue has room
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_not_full)
    else $error("frame pushed into full queue");

  // a pop needs a queued frame
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_out.valid)
    else $error("pop from empty queue");

  // coordinates and release never in one result
  a_touch_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_coord_valid && out_touch_release))
    else $error("coordinates reported with release");

  // key fields only on key packets
  a_key_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_packet_id != ID_KEY) |-> (!out_key_valid && out_key_code == 4'd0))
    else $error("key fields set on non-key packet");

endmodule

`default_nettype wire

FILE: tb/serial_frame_touch_key_decoder_unit_tb.sv
// testbench for serial_frame_touch_key_decoder_unit: byte stream stimulus, frame predictor
// and per-field result checking with random idling on both channels
// depends on sftkd_pkg and serial_frame_touch_key_decoder_unit
`timescale 1ns / 1ps

module serial_frame_touch_key_decoder_unit_tb import sftkd_pkg::*; ();

  typedef enum logic [1:0] {ST_HUNT, ST_HEAD, ST_BODY, ST_CLOSE} parse_phase_t;
  typedef enum int {CLOSE_EOF, CLOSE_SUM, CLOSE_BAD} close_kind_t;

  localparam int RANDOM_BYTES = 1350;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_LIMIT  = 4000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_packet_id;
  logic        out_key_valid;
  logic [3:0]  out_key_code;
  logic        out_key_pressed;
  logic        out_touch_press;
  logic        out_coord_valid;
  logic [15:0] out_x_pos;
  logic [15:0] out_y_pos;
  logic        out_touch_release;

  // predictor state
  parse_phase_t parse_phase;
  logic [3:0]   frame_id;
  logic [3:0]   frame_len;
  logic [3:0]   body_index;
  logic [7:0]   frame_sum;
  logic [7:0]   head_bytes [HEAD_BYTES];
  logic         touched;

  result_t pending_reports [$];
  result_t oldest_report;
  int      mismatch_count;
  int      bytes_sent;
  bit      tx_idle_on;
  bit      rx_idle_on;
  int      hold_request;
  int      hold_left;
  int      stall_left;

  serial_frame_touch_key_decoder_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_packet_id     (out_packet_id),
    .out_key_valid     (out_key_valid),
    .out_key_code      (out_key_code),
    .out_key_pressed   (out_key_pressed),
    .out_touch_press   (out_touch_press),
    .out_coord_valid   (out_coord_valid),
    .out_x_pos         (out_x_pos),
    .out_y_pos         (out_y_pos),
    .out_touch_release (out_touch_release)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

  // mismatch reporting
  task flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  // frame parser and decoder prediction, one accepted byte at a time
  task decode_rx_byte(input logic [7:0] b);
    result_t    r;
    logic [6:0] code;
    case (parse_phase)
      ST_HUNT: begin
        if (b == SOF_BYTE) parse_phase = ST_HEAD;
      end
      ST_HEAD: begin
        frame_id   = b[7:4];
        frame_len  = b[3:0];
        body_index = '0;
        if (frame_id >= ID_LIMIT) begin
          parse_phase = ST_HUNT;
        end else begin
          frame_sum   = b;
          parse_phase = (frame_len != 0) ? ST_BODY : ST_CLOSE;
        end
      end
      ST_BODY: begin
        frame_sum = frame_sum + b;
        if (body_index < HEAD_BYTES) head_bytes[body_index] = b;
        body_index = body_index + 4'd1;
        if (body_index == frame_len) parse_phase = ST_CLOSE;
      end
      default: begin
        parse_phase = ST_HUNT;
        if (b == EOF_BYTE || b == frame_sum) begin
          r = '0;
          r.packet_id = frame_id;
          if (frame_id == ID_KEY) begin
            code = head_bytes[0][6:0];
            if (code >= KEY_CODE_MIN && code <= KEY_CODE_MAX) begin
              r.key_valid   = 1'b1;
              r.key_code    = code[3:0];
              r.key_pressed = ~head_bytes[0][7];
            end
          end else if (frame_id == ID_TOUCH) begin
            if (!touched) begin
              r.touch_press = 1'b1;
              touched = 1'b1;
            end
            if (frame_len != 0) begin
              r.coord_valid = 1'b1;
              r.x_pos = {head_bytes[0], head_bytes[1]};
              r.y_pos = {head_bytes[2], head_bytes[3]};
            end else begin
              r.touch_release = 1'b1;
              touched = 1'b0;
            end
          end
          pending_reports.push_back(r);
        end
      end
    endcase
  endtask

  // result checking at each output transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("result with no frame pending");
      end else begin
        oldest_report = pending_reports.pop_front();
        check_field("packet_id", out_packet_id, oldest_report.packet_id);
        check_field("key_valid", out_key_valid, oldest_report.key_valid);
        check_field("key_code", out_key_code, oldest_report.key_code);
        check_field("key_pressed", out_key_pressed, oldest_report.key_pressed);
        check_field("touch_press", out_touch_press, oldest_report.touch_press);
        check_field("coord_valid", out_coord_valid, oldest_report.coord_valid);
        check_field("x_pos", out_x_pos, oldest_report.x_pos);
        check_field("y_pos", out_y_pos, oldest_report.y_pos);
        check_field("touch_release", out_touch_release, oldest_report.touch_release);
      end
    end
  end

  // receiver: long hold-off on request, random stall bursts otherwise
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one byte transfer; called and returns at a falling edge
  task send_byte(input logic [7:0] b);
    int gap;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_rx_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // whole frame: start, id/length, payload, closing byte
  // lead holds the first four payload bytes, byte 0 on top; later bytes are random
  task send_frame(input logic [3:0] id, input logic [3:0] len, input logic [31:0] lead,
                  input close_kind_t close);
    logic [7:0] hdr;
    logic [7:0] sum;
    logic [7:0] b;
    int         i;
    hdr = {id, len};
    sum = hdr;
    send_byte(SOF_BYTE);
    send_byte(hdr);
    for (i = 0; i < len; i++) begin
      b = (i < HEAD_BYTES) ? lead[31-8*i -: 8] : 8'($urandom_range(0, 255));
      sum = sum + b;
      send_byte(b);
    end
    case (close)
      CLOSE_EOF: b = EOF_BYTE;
      CLOSE_SUM: b = sum;
      default: begin
        b = 8'($urandom_range(0, 255));
        while (b == EOF_BYTE || b == sum) b = 8'($urandom_range(0, 255));
      end
    endcase
    send_byte(b);
  endtask

  task send_random_frame();
    int          pick;
    int          n;
    logic [3:0]  id;
    logic [3:0]  len;
    logic [31:0] lead;
    close_kind_t close;
    // occasional line noise or a cut-off frame ahead of the frame
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 5);
      repeat (n) begin
        send_byte(($urandom_range(0, 3) == 0) ? SOF_BYTE : 8'($urandom_range(0, 255)));
      end
    end
    lead = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      id  = ID_KEY;
      len = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd1;
      if ($urandom_range(0, 1) == 0) lead[31:24] = {1'($urandom()), 7'($urandom_range(0, 11))};
    end else if (pick < 85) begin
      id   = ID_TOUCH;
      pick = $urandom_range(0, 99);
      if (pick < 15) len = 4'd0;
      else if (pick < 70) len = 4'd4;
      else len = 4'($urandom_range(0, 15));
    end else begin
      id  = 4'($urandom_range(0, 15));
      len = 4'($urandom_range(0, 15));
    end
    pick = $urandom_range(0, 99);
    if (pick < 45) close = CLOSE_EOF;
    else if (pick < 90) close = CLOSE_SUM;
    else close = CLOSE_BAD;
    send_frame(id, len, lead, close);
  endtask

  // directed frames: field extremes, every packet kind and the corner cases
  task test_directed();
    send_frame(ID_KEY, 4'd1, 32'h01000000, CLOSE_EOF);
    send_frame(ID_KEY, 4'd1, 32'h89000000, CLOSE_SUM);
    send_frame(ID_KEY, 4'd1, 32'h0a000000, CLOSE_EOF);
    send_frame(ID_KEY, 4'd2, 32'h00ff0000, CLOSE_SUM);
    send_frame(ID_KEY, 4'd1, 32'h85000000, CLOSE_EOF);
    // key with no payload decodes the byte left by the last frame
    send_frame(ID_KEY, 4'd0, 32'h0, CLOSE_EOF);
    send_frame(ID_TOUCH, 4'd4, 32'hffffffff, CLOSE_SUM);
    send_frame(ID_TOUCH, 4'd4, 32'h00000000, CLOSE_EOF);
    // short touch payload keeps stale y bytes
    send_frame(ID_TOUCH, 4'd2, 32'h12340000, CLOSE_EOF);
    send_frame(ID_TOUCH, 4'd0, 32'h0, CLOSE_EOF);
    // zero-length touch while not touched: press and release together
    send_frame(ID_TOUCH, 4'd0, 32'h0, CLOSE_SUM);
    send_frame(4'd0, 4'd0, 32'h0, CLOSE_EOF);
    // long payload: only the first four bytes are kept, all go into the sum
    send_frame(4'd13, 4'd15, 32'hdeadbeef, CLOSE_SUM);
    // aborting ids fall back to hunting
    send_frame(4'd14, 4'd2, 32'h55aa0000, CLOSE_EOF);
    send_frame(4'd15, 4'd1, 32'h11000000, CLOSE_SUM);
    send_frame(ID_KEY, 4'd1, 32'h03000000, CLOSE_BAD);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h55);
    send_byte(8'haa);
    send_frame(ID_TOUCH, 4'd4, 32'h80017ffe, CLOSE_EOF);
  endtask

  // random frames, idling switched on and off in stretches
  task test_random_stream();
    int target;
    int frames;
    target = bytes_sent + RANDOM_BYTES;
    frames = 0;
    while (bytes_sent < target) begin
      if (frames % 20 == 0) begin
        tx_idle_on = ($urandom_range(0, 2) != 0);
        rx_idle_on = ($urandom_range(0, 2) != 0);
      end
      send_random_frame();
      frames++;
    end
  endtask

  // receiver holds off long enough for the frame queue to fill and stall the input
  task test_output_hold();
    tx_idle_on   = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (12) send_random_frame();
  endtask

  // closing stretch with no idling on either side
  task test_steady_stream();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (30) send_random_frame();
  endtask

  task wait_drain();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_reports.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", pending_reports.size()));
    end
  endtask

  // main sequence
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_rx_byte     = 8'h00;
    out_ready      = 1'b0;
    parse_phase    = ST_HUNT;
    frame_id       = '0;
    frame_len      = '0;
    body_index     = '0;
    frame_sum      = '0;
    touched        = 1'b0;
    for (int i = 0; i < HEAD_BYTES; i++) head_bytes[i] = '0;
    mismatch_count = 0;
    bytes_sent     = 0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    hold_request   = 0;
    hold_left      = 0;
    stall_left     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_output_hold();
    test_random_stream();
    test_steady_stream();
    wait_drain();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
